>>> rtl/rh2u_pkg.sv
// shared types, constants and register indexes for the half-to-unorm8 converter
package rh2u_pkg;

  localparam int unsigned NumChan     = 4;
  localparam int unsigned HalfW       = 16;
  localparam int unsigned OutW        = 8;
  localparam int unsigned MantW       = 11;
  localparam int unsigned ShiftW      = 5;
  localparam int unsigned CfgIdxW     = 4;
  localparam int unsigned CfgDataW    = 4;
  localparam int unsigned QueueDepthDefault = 2;

  localparam logic [3:0] BitDepthReset = 4'd8;
  localparam logic [3:0] BitDepthMax   = 4'd8;

  // configuration register indexes
  localparam logic [CfgIdxW-1:0] RegBitDepth    = CfgIdxW'(0);
  localparam logic [CfgIdxW-1:0] RegPremultiply = CfgIdxW'(1);

  // channel index of alpha
  localparam int unsigned AlphaIdx = 3;

  typedef enum logic [1:0] {
    KIND_ZERO = 2'd0,
    KIND_SAT  = 2'd1,
    KIND_NORM = 2'd2
  } chan_kind_e;

  typedef struct packed {
    chan_kind_e         kind;
    logic [MantW-1:0]   mant;
    logic [ShiftW-1:0]  shift;
  } chan_cls_t;

  typedef struct packed {
    chan_cls_t [NumChan-1:0] ch;
  } pix_cls_t;

  typedef struct packed {
    logic [3:0] bit_depth;
    logic       premultiply;
  } cfg_t;

endpackage

>>> rtl/rh2u_front.sv
// front end: takes start, decodes each binary16 channel into a class, mantissa and shift
module rh2u_front import rh2u_pkg::*; (
  input  logic                    start,
  output logic                    busy,
  input  logic [HalfW-1:0]        red_half_i,
  input  logic [HalfW-1:0]        green_half_i,
  input  logic [HalfW-1:0]        blue_half_i,
  input  logic [HalfW-1:0]        alpha_half_i,
  input  logic                    queue_full_i,
  output logic                    push_o,
  output pix_cls_t                push_data_o
);

  function automatic chan_cls_t classify(input logic [HalfW-1:0] h);
    logic       sgn;
    logic [4:0] ex;
    logic [9:0] frac;
    chan_cls_t  c;
    sgn  = h[15];
    ex   = h[14:10];
    frac = h[9:0];
    c.kind  = KIND_NORM;
    c.mant  = {1'b0, frac};
    c.shift = 5'd24;
    if (ex == 5'd31) begin
      c.kind = (frac != 10'd0 || sgn) ? KIND_ZERO : KIND_SAT;
    end else if (sgn) begin
      c.kind = KIND_ZERO;
    end else if (ex == 5'd0) begin
      // subnormal: value = frac * 2^-24
      c.mant  = {1'b0, frac};
      c.shift = 5'd24;
    end else if (ex >= 5'd25) begin
      c.kind = KIND_SAT;
    end else begin
      c.mant  = {1'b1, frac};
      c.shift = 5'd25 - ex;
    end
    return c;
  endfunction

  assign busy   = queue_full_i;
  assign push_o = start && !queue_full_i;

  always_comb begin
    push_data_o.ch[0] = classify(red_half_i);
    push_data_o.ch[1] = classify(green_half_i);
    push_data_o.ch[2] = classify(blue_half_i);
    push_data_o.ch[3] = classify(alpha_half_i);
  end

endmodule

>>> rtl/rh2u_queue.sv
// small fifo of decoded pixels between front and back
module rh2u_queue import rh2u_pkg::*; #(
  parameter int unsigned Depth = QueueDepthDefault
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     push_i,
  input  pix_cls_t push_data_i,
  input  logic     pop_i,
  output logic     full_o,
  output logic     valid_o,
  output pix_cls_t pop_data_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  pix_cls_t            mem_q [Depth];
  logic [PtrW-1:0]     wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0]     rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0]     count_q, count_d;
  logic                do_pop;

  assign full_o     = (count_q == CntW'(Depth));
  assign valid_o    = (count_q != '0);
  assign do_pop     = pop_i && valid_o;
  assign pop_data_o = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + PtrW'(1);
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + PtrW'(1);
    end
    if (push_i && !do_pop) begin
      count_d = count_q + CntW'(1);
    end else if (!push_i && do_pop) begin
      count_d = count_q - CntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

endmodule

>>> rtl/rh2u_back.sv
// back end: scale, round and clamp each channel, then optional alpha premultiply
module rh2u_back import rh2u_pkg::*; (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  cfg_t            cfg_i,
  input  logic            in_valid_i,
  input  pix_cls_t        in_data_i,
  output logic            pop_o,
  output logic            out_strobe_o,
  output logic [OutW-1:0] red_out_o,
  output logic [OutW-1:0] green_out_o,
  output logic [OutW-1:0] blue_out_o,
  output logic [OutW-1:0] alpha_out_o
);

  localparam int unsigned ProdW = MantW + OutW;
  localparam int unsigned SumW  = 25;

  logic [3:0]      depth;
  logic [OutW-1:0] full_scale;

  logic            s1_valid_q;
  logic [OutW-1:0] s1_chan_q [NumChan];
  logic [OutW-1:0] s1_chan_d [NumChan];

  logic            s2_valid_q;
  logic [OutW-1:0] s2_chan_q [NumChan];
  logic [OutW-1:0] s2_chan_d [NumChan];

  assign pop_o = in_valid_i;

  assign depth      = (cfg_i.bit_depth > BitDepthMax) ? BitDepthMax : cfg_i.bit_depth;
  assign full_scale = OutW'((9'd1 << depth) - 9'd1);

  // stage 1: m * F, round half up at the binary point, clamp to F
  always_comb begin
    logic [ProdW-1:0] prod;
    logic [SumW-1:0]  sum;
    logic [SumW-1:0]  r;
    for (int i = 0; i < NumChan; i++) begin
      prod = ProdW'(in_data_i.ch[i].mant) * ProdW'(full_scale);
      sum  = SumW'(prod) + (SumW'(1) << (in_data_i.ch[i].shift - ShiftW'(1)));
      r    = sum >> in_data_i.ch[i].shift;
      case (in_data_i.ch[i].kind)
        KIND_ZERO: s1_chan_d[i] = '0;
        KIND_SAT:  s1_chan_d[i] = full_scale;
        default:   s1_chan_d[i] = (r > SumW'(full_scale)) ? full_scale : r[OutW-1:0];
      endcase
    end
  end

  // stage 2: c * a / 255 via exact reciprocal form (p + (p >> 8) + 1) >> 8
  always_comb begin
    logic [2*OutW-1:0] p;
    logic [2*OutW:0]   q;
    for (int i = 0; i < NumChan; i++) begin
      p = (2*OutW)'(s1_chan_q[i]) * (2*OutW)'(s1_chan_q[AlphaIdx]);
      q = (2*OutW+1)'(p) + (2*OutW+1)'(p >> OutW) + (2*OutW+1)'(1);
      if (cfg_i.premultiply && i != AlphaIdx) begin
        s2_chan_d[i] = q[2*OutW-1:OutW];
      end else begin
        s2_chan_d[i] = s1_chan_q[i];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      s2_valid_q <= 1'b0;
    end else begin
      s1_valid_q <= in_valid_i;
      s2_valid_q <= s1_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    s1_chan_q <= s1_chan_d;
    s2_chan_q <= s2_chan_d;
  end

  assign out_strobe_o = s2_valid_q;
  assign red_out_o    = s2_chan_q[0];
  assign green_out_o  = s2_chan_q[1];
  assign blue_out_o   = s2_chan_q[2];
  assign alpha_out_o  = s2_chan_q[AlphaIdx];

endmodule

>>> rtl/rgba_half_to_unorm8.sv
// top level of the rgba binary16 to unorm8 pixel converter
// usage:
//   a pixel of four binary16 channels is taken at a rising edge with start high
//   and busy low; each channel is scaled by 2^depth - 1, rounded half away from
//   zero and clamped, negatives and nan give zero, plus infinity saturates
//   results sit on the ports for exactly one cycle, after the queue, stage 1 and
//   stage 2 registers, marked by out_strobe_o; the receiver cannot stall them
//   throughput is one pixel per clock: the front decodes into a small queue and
//   the back drains it every cycle through a two-stage multiply pipeline
//   (scale multiply, then alpha multiply with divide by 255 as reciprocal)
//   busy rises only if the queue fills, which a free-running back never allows
//   configuration: cfg_valid_i/cfg_ready_o transfer with index 0 = bit depth,
//   index 1 = premultiply enable; ready is always high, other indexes ignored;
//   write only while no pixel is in flight
//   reset: depth 8, premultiply off, queue empty, no strobe
module rgba_half_to_unorm8 import rh2u_pkg::*; #(
  parameter int unsigned QueueDepth = QueueDepthDefault
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start,
  output logic                busy,
  input  logic [HalfW-1:0]    red_half_i,
  input  logic [HalfW-1:0]    green_half_i,
  input  logic [HalfW-1:0]    blue_half_i,
  input  logic [HalfW-1:0]    alpha_half_i,
  output logic                out_strobe_o,
  output logic [OutW-1:0]     red_out_o,
  output logic [OutW-1:0]     green_out_o,
  output logic [OutW-1:0]     blue_out_o,
  output logic [OutW-1:0]     alpha_out_o,
  input  logic                cfg_valid_i,
  output logic                cfg_ready_o,
  input  logic [CfgIdxW-1:0]  cfg_index_i,
  input  logic [CfgDataW-1:0] cfg_data_i
);

  cfg_t     cfg_q, cfg_d;
  logic     push;
  pix_cls_t push_data;
  logic     queue_full;
  logic     queue_valid;
  pix_cls_t queue_data;
  logic     pop;

  // config registers, always ready
  assign cfg_ready_o = 1'b1;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_valid_i) begin
      unique case (cfg_index_i)
        RegBitDepth:    cfg_d.bit_depth   = cfg_data_i[3:0];
        RegPremultiply: cfg_d.premultiply = cfg_data_i[0];
        default:        cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.bit_depth   <= BitDepthReset;
      cfg_q.premultiply <= 1'b0;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  // front: accept and decode channels
  rh2u_front u_front (
    .start        (start),
    .busy         (busy),
    .red_half_i   (red_half_i),
    .green_half_i (green_half_i),
    .blue_half_i  (blue_half_i),
    .alpha_half_i (alpha_half_i),
    .queue_full_i (queue_full),
    .push_o       (push),
    .push_data_o  (push_data)
  );

  // decoded pixels wait here for the back end
  rh2u_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (push_data),
    .pop_i       (pop),
    .full_o      (queue_full),
    .valid_o     (queue_valid),
    .pop_data_o  (queue_data)
  );

  // back: scale, round, clamp, premultiply, register results
  rh2u_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_i        (cfg_q),
    .in_valid_i   (queue_valid),
    .in_data_i    (queue_data),
    .pop_o        (pop),
    .out_strobe_o (out_strobe_o),
    .red_out_o    (red_out_o),
    .green_out_o  (green_out_o),
    .blue_out_o   (blue_out_o),
    .alpha_out_o  (alpha_out_o)
  );

endmodule

>>> test/tb.sv
// testbench for the rgba binary16 to unorm8 pixel converter
`timescale 1ns / 1ps

module tb;
  import rh2u_pkg::*;

  localparam int unsigned CycleLimit = 400000;
  localparam int unsigned MaxGap     = 17;
  localparam int unsigned DrainWait  = 6;    // margin after the last result for the queue and pipeline to settle
  localparam int unsigned ReportMax  = 10;

  // no register lives at this index, so the block ignores writes to it
  localparam logic [CfgIdxW-1:0] RegSpare = CfgIdxW'(5);

  // binary16 patterns that mark the corners of the conversion
  localparam logic [HalfW-1:0] HalfPosZero = 16'h0000;
  localparam logic [HalfW-1:0] HalfNegZero = 16'h8000;
  localparam logic [HalfW-1:0] HalfOne     = 16'h3C00;
  localparam logic [HalfW-1:0] HalfHalf    = 16'h3800;
  localparam logic [HalfW-1:0] HalfPosInf  = 16'h7C00;
  localparam logic [HalfW-1:0] HalfNegInf  = 16'hFC00;
  localparam logic [HalfW-1:0] HalfQNan    = 16'h7E00;
  localparam logic [HalfW-1:0] HalfNegNan  = 16'hFE00;
  localparam logic [HalfW-1:0] HalfMaxNorm = 16'h7BFF;
  localparam logic [HalfW-1:0] HalfMinSub  = 16'h0001;
  localparam logic [HalfW-1:0] HalfMaxSub  = 16'h03FF;

  typedef struct packed {
    logic [HalfW-1:0] red;
    logic [HalfW-1:0] green;
    logic [HalfW-1:0] blue;
    logic [HalfW-1:0] alpha;
  } half_px_t;

  typedef struct packed {
    logic [OutW-1:0] red;
    logic [OutW-1:0] green;
    logic [OutW-1:0] blue;
    logic [OutW-1:0] alpha;
  } unorm_px_t;

  // clock and reset
  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  always #6 clk_i = ~clk_i;

  // block inputs, all known from time zero
  logic                start        = 1'b0;
  logic [HalfW-1:0]    red_half_i   = '0;
  logic [HalfW-1:0]    green_half_i = '0;
  logic [HalfW-1:0]    blue_half_i  = '0;
  logic [HalfW-1:0]    alpha_half_i = '0;
  logic                cfg_valid_i  = 1'b0;
  logic [CfgIdxW-1:0]  cfg_index_i  = '0;
  logic [CfgDataW-1:0] cfg_data_i   = '0;

  // block outputs
  logic            busy;
  logic            out_strobe_o;
  logic [OutW-1:0] red_out_o;
  logic [OutW-1:0] green_out_o;
  logic [OutW-1:0] blue_out_o;
  logic [OutW-1:0] alpha_out_o;
  logic            cfg_ready_o;

  rgba_half_to_unorm8 DUT (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .start        (start),
    .busy         (busy),
    .red_half_i   (red_half_i),
    .green_half_i (green_half_i),
    .blue_half_i  (blue_half_i),
    .alpha_half_i (alpha_half_i),
    .out_strobe_o (out_strobe_o),
    .red_out_o    (red_out_o),
    .green_out_o  (green_out_o),
    .blue_out_o   (blue_out_o),
    .alpha_out_o  (alpha_out_o),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_ready_o  (cfg_ready_o),
    .cfg_index_i  (cfg_index_i),
    .cfg_data_i   (cfg_data_i)
  );

  // predictor's own copy of the two registers, reset values of the block
  logic [3:0] depth_cfg   = BitDepthReset;
  logic       premul_cfg  = 1'b0;

  half_px_t  half_px_q[$];    // pixels waiting to be driven
  unorm_px_t unorm_due_q[$];  // converted pixels due on the output, oldest first

  int unsigned cycle_count = 0;
  int unsigned n_sent      = 0;
  int unsigned n_checked   = 0;
  int unsigned n_mismatch  = 0;
  int unsigned n_settings  = 0;

  bit pix_taken = 1'b0;       // start transfer happened at the last rising edge

  // ---------------------------------------------------------------------------
  // predictor
  // ---------------------------------------------------------------------------

  // exact scale by the full scale, round half away from zero, clamp
  function automatic logic [OutW-1:0] unorm_of_half(logic [HalfW-1:0] h, logic [7:0] full);
    logic        sgn;
    logic [4:0]  ex;
    logic [9:0]  frac;
    logic [10:0] mant;
    int unsigned e;
    int unsigned sh;
    logic [39:0] prod;
    logic [39:0] rnd;
    sgn  = h[15];
    ex   = h[14:10];
    frac = h[9:0];
    if (ex == 5'd31) begin
      // nan of either sign and minus infinity give zero, plus infinity saturates
      return (frac != 0 || sgn) ? '0 : full;
    end
    if (sgn) return '0;
    if (ex == 0) begin
      mant = {1'b0, frac};
      e    = 1;
    end else begin
      mant = {1'b1, frac};
      e    = ex;
    end
    // value is mant * 2^(e-25); from e = 25 on it is at least 1024
    if (e >= 25) return (mant == 0 || full == 0) ? '0 : full;
    prod = 40'(mant) * 40'(full);
    sh   = 25 - e;
    rnd  = (prod + (40'd1 << (sh - 1))) >> sh;
    if (rnd > 40'(full)) rnd = 40'(full);
    return rnd[OutW-1:0];
  endfunction

  function automatic unorm_px_t convert_pixel(half_px_t px, logic [3:0] depth, logic premul);
    logic [3:0]  d;
    logic [7:0]  full;
    unorm_px_t   res;
    logic [15:0] prod_r;
    logic [15:0] prod_g;
    logic [15:0] prod_b;
    d    = (depth > BitDepthMax) ? BitDepthMax : depth;
    full = 8'((9'd1 << d) - 9'd1);
    res.red   = unorm_of_half(px.red, full);
    res.green = unorm_of_half(px.green, full);
    res.blue  = unorm_of_half(px.blue, full);
    res.alpha = unorm_of_half(px.alpha, full);
    if (premul) begin
      // divisor stays 255 at every depth
      prod_r    = 16'(res.red) * 16'(res.alpha);
      prod_g    = 16'(res.green) * 16'(res.alpha);
      prod_b    = 16'(res.blue) * 16'(res.alpha);
      res.red   = 8'(prod_r / 16'd255);
      res.green = 8'(prod_g / 16'd255);
      res.blue  = 8'(prod_b / 16'd255);
    end
    return res;
  endfunction

  // ---------------------------------------------------------------------------
  // stimulus helpers
  // ---------------------------------------------------------------------------

  // channel values biased toward the 0..1 range where rounding matters
  function automatic logic [HalfW-1:0] pick_half();
    logic [HalfW-1:0] v;
    case ($urandom_range(0, 11))
      0, 1: v = 16'($urandom);
      2: begin
        case ($urandom_range(0, 7))
          0: v = HalfPosInf;
          1: v = HalfNegInf;
          2: v = {1'b0, 5'd31, 10'($urandom_range(1, 1023))};   // nan
          3: v = {1'b1, 5'd31, 10'($urandom)};                  // negative nan or -inf
          4: v = HalfNegZero;
          5: v = HalfOne;
          6: v = HalfHalf;
          default: v = HalfMaxNorm;
        endcase
      end
      3, 4, 5, 6: v = {1'b0, 5'($urandom_range(0, 14)), 10'($urandom)};
      7: v = {1'b0, 5'd15, 10'($urandom_range(0, 3))};          // just at or above one
      8: v = {6'b0, 10'($urandom)};                             // subnormal
      9: v = {1'b1, 5'($urandom_range(0, 14)), 10'($urandom)};  // small negative
      10: v = {1'b0, 5'($urandom_range(10, 14)), 10'($urandom) & 10'h3C0};  // few mantissa bits
      default: v = {1'b0, 5'($urandom_range(15, 30)), 10'($urandom)};       // at or above one
    endcase
    return v;
  endfunction

  task automatic queue_random(int unsigned n);
    half_px_t px;
    repeat (n) begin
      px.red   = pick_half();
      px.green = pick_half();
      px.blue  = pick_half();
      px.alpha = pick_half();
      half_px_q.push_back(px);
    end
  endtask

  task automatic queue_pixel(logic [HalfW-1:0] r, logic [HalfW-1:0] g,
                             logic [HalfW-1:0] b, logic [HalfW-1:0] a);
    half_px_q.push_back('{red: r, green: g, blue: b, alpha: a});
  endtask

  // wait for every pixel to come back, then let the pipeline settle
  task automatic wait_drained();
    while (half_px_q.size() != 0 || start || unorm_due_q.size() != 0) @(posedge clk_i);
    repeat (DrainWait) @(posedge clk_i);
  endtask

  // valid is left high between back-to-back writes; cfg_release lowers it
  task automatic cfg_write(logic [CfgIdxW-1:0] idx, logic [CfgDataW-1:0] data);
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
  endtask

  task automatic cfg_release();
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
    cfg_index_i <= CfgIdxW'($urandom);
    cfg_data_i  <= CfgDataW'($urandom);
  endtask

  // program one setting while idle; the upper data bits of the premultiply
  // write are random since only bit zero counts
  task automatic set_mode(logic [3:0] depth, logic premul);
    wait_drained();
    cfg_write(RegBitDepth, depth);
    cfg_write(RegPremultiply, {(CfgDataW-1)'($urandom), premul});
    if ($urandom_range(0, 2) == 0) cfg_write(RegSpare, CfgDataW'($urandom));
    cfg_release();
    n_settings++;
  endtask

  // ---------------------------------------------------------------------------
  // driver: start transfers at the falling edge, random gaps with burst stretches
  // ---------------------------------------------------------------------------

  int unsigned gap_left  = 0;
  bit          burst     = 1'b0;
  bit          start_nxt;
  half_px_t    drv_px;

  always @(negedge clk_i) begin
    if (rst_ni) begin
      start_nxt = start && !pix_taken;
      if (start && pix_taken) begin
        gap_left = burst ? 0 : $urandom_range(0, MaxGap);
        if ($urandom_range(0, 39) == 0) burst = !burst;
      end
      if (!start_nxt) begin
        if (gap_left != 0) begin
          gap_left--;
        end else if (half_px_q.size() != 0) begin
          drv_px        = half_px_q.pop_front();
          start_nxt     = 1'b1;
          red_half_i   <= drv_px.red;
          green_half_i <= drv_px.green;
          blue_half_i  <= drv_px.blue;
          alpha_half_i <= drv_px.alpha;
        end
      end
      start <= start_nxt;
    end
  end

  // ---------------------------------------------------------------------------
  // monitor: tracks config writes, predicts on start transfers, checks strobes
  // ---------------------------------------------------------------------------

  unorm_px_t got;
  unorm_px_t want;

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CycleLimit) begin
      $display("timeout after %0d cycles, %0d results still due", cycle_count,
               unorm_due_q.size());
      $display("FAILED: results differ");
      $finish;
    end else begin
      pix_taken = 1'b0;
      if (rst_ni) begin
        if (cfg_valid_i && cfg_ready_o) begin
          case (cfg_index_i)
            RegBitDepth:    depth_cfg  = cfg_data_i[3:0];
            RegPremultiply: premul_cfg = cfg_data_i[0];
            default: ;
          endcase
        end
        // check the strobe before queuing a new prediction
        if (out_strobe_o) begin
          got = '{red: red_out_o, green: green_out_o, blue: blue_out_o, alpha: alpha_out_o};
          if (unorm_due_q.size() == 0) begin
            n_mismatch++;
            if (n_mismatch <= ReportMax)
              $display("cycle %0d: unexpected result r=%0d g=%0d b=%0d a=%0d",
                       cycle_count, got.red, got.green, got.blue, got.alpha);
          end else begin
            want = unorm_due_q.pop_front();
            n_checked++;
            if (got.red !== want.red || got.green !== want.green ||
                got.blue !== want.blue || got.alpha !== want.alpha) begin
              n_mismatch++;
              if (n_mismatch <= ReportMax)
                $display("cycle %0d: expected r=%0d g=%0d b=%0d a=%0d, got r=%0d g=%0d b=%0d a=%0d",
                         cycle_count, want.red, want.green, want.blue, want.alpha,
                         got.red, got.green, got.blue, got.alpha);
            end
          end
        end
        if (start && !busy) begin
          pix_taken = 1'b1;
          n_sent++;
          unorm_due_q.push_back(convert_pixel(
            '{red: red_half_i, green: green_half_i, blue: blue_half_i, alpha: alpha_half_i},
            depth_cfg, premul_cfg));
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // test sequence
  // ---------------------------------------------------------------------------

  initial begin
    repeat (9) @(negedge clk_i);
    rst_ni = 1'b1;

    // full depth, straight alpha: corner values first
    set_mode(4'd8, 1'b0);
    queue_pixel(HalfPosZero, HalfPosZero, HalfPosZero, HalfPosZero);
    queue_pixel(HalfOne, HalfOne, HalfOne, HalfOne);
    queue_pixel(HalfPosInf, HalfNegInf, HalfQNan, HalfNegNan);
    queue_pixel(HalfNegZero, HalfMaxNorm, HalfMinSub, HalfPosInf);
    queue_pixel(HalfMaxSub, HalfHalf, 16'h3BFF, 16'h3C01);      // just below and above one
    queue_pixel(16'h8001, 16'hBC00, 16'hFFFF, 16'h7FFF);        // tiny negative, -1, nans
    queue_pixel(16'h6400, 16'h63FF, 16'h5BF8, HalfHalf);        // around 1024, and 255
    queue_pixel(16'h37FF, 16'h3801, 16'h3400, 16'h3A00);        // either side of one half
    queue_pixel(16'h0400, 16'h2000, 16'h1C00, 16'h1800);        // smallest normal, small powers
    queue_pixel(16'h5555, 16'hAAAA, 16'h2AAA, 16'hD555);
    queue_pixel(16'h1E00, 16'h1A00, 16'h0200, 16'h3B00);
    queue_pixel(16'hFBFF, 16'h7C01, 16'h83FF, 16'h3FFF);
    queue_random(60);

    set_mode(4'd8, 1'b1);
    queue_pixel(HalfOne, HalfHalf, HalfMaxSub, HalfHalf);
    queue_pixel(HalfPosInf, HalfOne, 16'h3A00, HalfPosInf);
    queue_pixel(HalfOne, HalfOne, HalfOne, HalfNegNan);         // zero alpha wipes color
    queue_random(70);

    set_mode(4'd1, 1'b0);
    queue_pixel(HalfHalf, 16'h37FF, 16'h3801, HalfOne);         // rounding at one bit
    queue_random(50);
    set_mode(4'd1, 1'b1);                                       // divisor still 255
    queue_random(50);
    set_mode(4'd0, 1'b1);                                       // zero full scale
    queue_pixel(HalfPosInf, HalfOne, HalfMaxNorm, HalfPosInf);
    queue_random(30);
    set_mode(4'd15, 1'b1);                                      // depth above eight
    queue_random(40);
    set_mode(4'd9, 1'b0);
    queue_random(30);
    set_mode(4'd4, 1'b1);
    queue_random(50);
    repeat (8) begin
      set_mode(4'($urandom_range(0, 15)), 1'($urandom));
      queue_random(40);
    end

    wait_drained();
    $display("%0d pixels sent, %0d results checked across %0d register settings",
             n_sent, n_checked, n_settings);
    $display("depths 0, 1, 4, 8, 9 and 15 plus random ones, premultiply on and off");
    if (n_mismatch == 0 && unorm_due_q.size() == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("%0d mismatches, %0d results never arrived", n_mismatch, unorm_due_q.size());
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule
